### rtl/core/qsp_pkg.sv
`default_nettype none

package qsp_pkg;

    // Capacity of the direction memory by default.
    localparam int MAX_DIRECTIONS_DEF = 64;

    // Field widths fixed by the fixed-point formats.
    localparam int COS_W   = 16;   // Q1.14 direction cosine
    localparam int WGT_W   = 16;   // raw and normalised weight
    localparam int TOTAL_W = 22;   // running weight sum
    localparam int TOL_W   = 11;   // match tolerance
    localparam int IDX_W   = 6;    // direction index on the result ports
    localparam int COEF_W  = 17;   // differencing coefficient
    localparam int ACC_W   = 34;   // level accumulator
    localparam int PROD_W  = 33;   // weight times cosine
    localparam int DVD_W   = 32;   // dividend of the weight normalisation
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = 5;

    localparam logic [TOL_W-1:0] TOL_RESET = 11'd2;

    // Packed memory word: {level_end, weight, xi, mu}.
    localparam int RAM_W     = 1 + WGT_W + 2 * COS_W;
    localparam int MU_LSB    = 0;
    localparam int XI_LSB    = COS_W;
    localparam int WGT_LSB   = 2 * COS_W;
    localparam int LEND_BIT  = 2 * COS_W + WGT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_ROW,
        ST_SEARCH,
        ST_DIVWAIT,
        ST_MUL,
        ST_EMIT
    } qsp_state_t;

    // Magnitude of a 17 bit two's complement value, read as unsigned.
    function automatic logic [COS_W:0] mag17(input logic signed [COS_W:0] v);
        logic [COS_W:0] r;
        r = v[COS_W] ? (COS_W+1)'(-v) : v;
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/quadrature_set_postprocess.sv
`default_nettype none

// Direction set post-processor. Directions are loaded one request per clock
// cycle while busy is low: a request is taken at a rising edge with start high
// and busy low. Directions past MAX_DIRECTIONS are dropped and reported
// through overflowed. The request that carries set_end raises busy and starts
// the output pass, which gives one result per stored direction in index
// order. Each result is shown for exactly one cycle with result_valid high;
// the receiver cannot hold results back, so it must take every strobe. For
// each result of a set of n directions, the mirror search walks all n entries
// through the single read port of the direction memory, and the weight
// normalisation is a 16-step serial divider that runs alongside it. Busy
// falls as the final result is shown, and a new set may be loaded. The tolerance
// register may only be written while busy is low and no result is pending.
module quadrature_set_postprocess #(
    parameter int MAX_DIRECTIONS = qsp_pkg::MAX_DIRECTIONS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Tolerance register.
    input  wire logic                              cfg_we,
    input  wire logic [qsp_pkg::TOL_W-1:0]         cfg_wdata,
    // Load requests.
    input  wire logic                              start,
    output      logic                              busy,
    input  wire logic signed [qsp_pkg::COS_W-1:0]  dir_mu,
    input  wire logic signed [qsp_pkg::COS_W-1:0]  dir_xi,
    input  wire logic [qsp_pkg::WGT_W-1:0]         raw_weight,
    input  wire logic                              level_end,
    input  wire logic                              set_end,
    // Results.
    output      logic                              result_valid,
    output      logic [qsp_pkg::IDX_W-1:0]         direction,
    output      logic [qsp_pkg::WGT_W-1:0]         norm_weight,
    output      logic signed [qsp_pkg::COEF_W-1:0] diff_coeff,
    output      logic [qsp_pkg::IDX_W-1:0]         mu_partner,
    output      logic [qsp_pkg::IDX_W-1:0]         xi_partner,
    output      logic [qsp_pkg::IDX_W-1:0]         both_partner,
    output      logic                              overflowed,
    output      logic                              last
);

    localparam int AW    = $clog2(MAX_DIRECTIONS);
    localparam int CNT_W = $clog2(MAX_DIRECTIONS + 1);
    localparam int CW    = qsp_pkg::COS_W;

    // Control state.
    qsp_pkg::qsp_state_t state_reg, state_next;
    logic [CNT_W-1:0]              count_reg;
    logic [qsp_pkg::TOTAL_W-1:0]   total_reg;
    logic                          ovf_reg;
    logic [qsp_pkg::TOL_W-1:0]     tol_reg;
    logic [AW-1:0]                 i_reg;
    logic [AW-1:0]                 j_reg;
    logic                          res_valid_reg;

    // Datapath registers for the direction in hand.
    logic signed [CW-1:0]           row_mu_reg;
    logic signed [CW-1:0]           row_xi_reg;
    logic                           row_lend_reg;
    logic [qsp_pkg::IDX_W-1:0]      pm_reg, px_reg, pb_reg;
    logic [qsp_pkg::WGT_W-1:0]      nw_reg;
    logic signed [qsp_pkg::PROD_W-1:0] prod_reg;
    logic signed [qsp_pkg::ACC_W-1:0]  acc_reg;
    logic signed [qsp_pkg::COEF_W-1:0] coeff_reg;

    // Result registers.
    logic [qsp_pkg::IDX_W-1:0]         dir_out_reg;
    logic [qsp_pkg::WGT_W-1:0]         nw_out_reg;
    logic signed [qsp_pkg::COEF_W-1:0] coeff_out_reg;
    logic [qsp_pkg::IDX_W-1:0]         pm_out_reg, px_out_reg, pb_out_reg;
    logic                              ovf_out_reg, last_out_reg;

    // Memory and divider wiring.
    logic                       accept;
    logic                       ram_we;
    logic [AW-1:0]              ram_raddr;
    logic [qsp_pkg::RAM_W-1:0]  ram_wdata;
    logic [qsp_pkg::RAM_W-1:0]  ram_rdata;
    logic                       div_start;
    logic                       div_busy;
    logic [qsp_pkg::WGT_W-1:0]  div_quot;
    logic [qsp_pkg::DVD_W-1:0]  dividend;
    logic                       room;
    logic                       is_last;
    logic                       search_done;

    // Search datapath.
    logic signed [CW-1:0] rd_mu, rd_xi;
    logic [CW:0]          m_sum_mag, m_dif_mag, x_sum_mag, x_dif_mag;
    logic                 m_sum_ok, m_dif_ok, x_sum_ok, x_dif_ok;

    // Coefficient rounding.
    logic signed [qsp_pkg::ACC_W-1:0]   neg_rnd;
    logic signed [qsp_pkg::ACC_W-1:0]   scaled;
    logic signed [qsp_pkg::COEF_W-1:0]  coeff_next;
    logic signed [qsp_pkg::PROD_W-1:0]  prod_next;
    logic signed [qsp_pkg::ACC_W-1:0]   acc_sum;

    localparam logic signed [qsp_pkg::ACC_W-1:0] SAT_HI = qsp_pkg::ACC_W'(32768);
    localparam logic signed [qsp_pkg::ACC_W-1:0] SAT_LO = -qsp_pkg::ACC_W'(32768);
    localparam logic signed [qsp_pkg::ACC_W-1:0] HALF_LSB = qsp_pkg::ACC_W'(8192);

    assign room        = (count_reg < CNT_W'(MAX_DIRECTIONS));
    assign is_last     = (CNT_W'(i_reg) == count_reg - 1'b1);
    assign search_done = (CNT_W'(j_reg) == count_reg - 1'b1);

    // The direction memory holds mu, xi, weight and the level mark together.
    assign ram_wdata = {level_end, raw_weight, dir_xi, dir_mu};

    qsp_ram #(
        .WIDTH (qsp_pkg::RAM_W),
        .DEPTH (MAX_DIRECTIONS)
    ) u_dir_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Dividend is weight * 32768 plus half the total, so the quotient rounds
    // to nearest with halves going up.
    assign dividend = {1'b0, ram_rdata[qsp_pkg::WGT_LSB +: qsp_pkg::WGT_W], 15'd0}
                      + qsp_pkg::DVD_W'(total_reg >> 1);

    qsp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (total_reg),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // Mirror tests between the held direction and the entry being read.
    assign rd_mu = ram_rdata[qsp_pkg::MU_LSB +: CW];
    assign rd_xi = ram_rdata[qsp_pkg::XI_LSB +: CW];

    assign m_sum_mag = qsp_pkg::mag17((CW+1)'(row_mu_reg) + (CW+1)'(rd_mu));
    assign m_dif_mag = qsp_pkg::mag17((CW+1)'(row_mu_reg) - (CW+1)'(rd_mu));
    assign x_sum_mag = qsp_pkg::mag17((CW+1)'(row_xi_reg) + (CW+1)'(rd_xi));
    assign x_dif_mag = qsp_pkg::mag17((CW+1)'(row_xi_reg) - (CW+1)'(rd_xi));

    assign m_sum_ok = (m_sum_mag <= (CW+1)'(tol_reg));
    assign m_dif_ok = (m_dif_mag <= (CW+1)'(tol_reg));
    assign x_sum_ok = (x_sum_mag <= (CW+1)'(tol_reg));
    assign x_dif_ok = (x_dif_mag <= (CW+1)'(tol_reg));

    // The coefficient is minus the level sum so far, rounded to the nearest
    // 2^-15 with halves up, then clamped to plus or minus 1.0.
    assign neg_rnd = HALF_LSB - acc_reg;
    assign scaled  = neg_rnd >>> 14;

    always_comb
    begin
        if (scaled > SAT_HI)
        begin
            coeff_next = qsp_pkg::COEF_W'(SAT_HI);
        end
        else if (scaled < SAT_LO)
        begin
            coeff_next = qsp_pkg::COEF_W'(SAT_LO);
        end
        else
        begin
            coeff_next = qsp_pkg::COEF_W'(scaled);
        end
    end

    assign prod_next = $signed({1'b0, nw_reg}) * row_mu_reg;
    assign acc_sum   = acc_reg + {{(qsp_pkg::ACC_W - qsp_pkg::PROD_W){prod_reg[qsp_pkg::PROD_W-1]}},
                                  prod_reg};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            qsp_pkg::ST_IDLE:
            begin
                if (accept && set_end)
                begin
                    state_next = qsp_pkg::ST_FETCH;
                end
            end
            qsp_pkg::ST_FETCH:
            begin
                state_next = qsp_pkg::ST_ROW;
            end
            qsp_pkg::ST_ROW:
            begin
                state_next = qsp_pkg::ST_SEARCH;
            end
            qsp_pkg::ST_SEARCH:
            begin
                if (search_done)
                begin
                    state_next = qsp_pkg::ST_DIVWAIT;
                end
            end
            qsp_pkg::ST_DIVWAIT:
            begin
                if (!div_busy)
                begin
                    state_next = qsp_pkg::ST_MUL;
                end
            end
            qsp_pkg::ST_MUL:
            begin
                state_next = qsp_pkg::ST_EMIT;
            end
            qsp_pkg::ST_EMIT:
            begin
                state_next = is_last ? qsp_pkg::ST_IDLE : qsp_pkg::ST_FETCH;
            end
            default:
            begin
                state_next = qsp_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        busy      = 1'b1;
        ram_we    = 1'b0;
        ram_raddr = '0;
        div_start = 1'b0;
        unique case (state_reg) inside
            qsp_pkg::ST_IDLE:
            begin
                busy   = 1'b0;
                ram_we = start && room;
            end
            qsp_pkg::ST_FETCH:
            begin
                ram_raddr = i_reg;
            end
            qsp_pkg::ST_ROW:
            begin
                div_start = 1'b1;
            end
            qsp_pkg::ST_SEARCH:
            begin
                ram_raddr = j_reg + 1'b1;
            end
            qsp_pkg::ST_DIVWAIT,
            qsp_pkg::ST_MUL,
            qsp_pkg::ST_EMIT:
            begin
                ram_raddr = '0;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    assign accept = start && !busy;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qsp_pkg::ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            tol_reg       <= qsp_pkg::TOL_RESET;
            i_reg         <= '0;
            j_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= (state_reg == qsp_pkg::ST_EMIT);
            if (cfg_we)
            begin
                tol_reg <= cfg_wdata;
            end
            if (accept)
            begin
                if (room)
                begin
                    count_reg <= count_reg + 1'b1;
                    total_reg <= qsp_pkg::TOTAL_W'(total_reg + raw_weight);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
                i_reg <= '0;
            end
            if (state_reg == qsp_pkg::ST_ROW)
            begin
                j_reg <= '0;
            end
            if (state_reg == qsp_pkg::ST_SEARCH)
            begin
                j_reg <= j_reg + 1'b1;
            end
            if (state_reg == qsp_pkg::ST_EMIT)
            begin
                if (is_last)
                begin
                    // The set is finished: make room for the next one.
                    count_reg <= '0;
                    total_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
                else
                begin
                    i_reg <= i_reg + 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            acc_reg <= '0;
        end
        if (state_reg == qsp_pkg::ST_ROW)
        begin
            row_mu_reg   <= ram_rdata[qsp_pkg::MU_LSB +: CW];
            row_xi_reg   <= ram_rdata[qsp_pkg::XI_LSB +: CW];
            row_lend_reg <= ram_rdata[qsp_pkg::LEND_BIT];
            pm_reg       <= '0;
            px_reg       <= '0;
            pb_reg       <= '0;
        end
        if (state_reg == qsp_pkg::ST_SEARCH)
        begin
            // Later matches overwrite earlier ones.
            if (m_sum_ok && x_dif_ok)
            begin
                pm_reg <= qsp_pkg::IDX_W'(j_reg);
            end
            if (m_dif_ok && x_sum_ok)
            begin
                px_reg <= qsp_pkg::IDX_W'(j_reg);
            end
            if (m_sum_ok && x_sum_ok)
            begin
                pb_reg <= qsp_pkg::IDX_W'(j_reg);
            end
        end
        if (state_reg == qsp_pkg::ST_DIVWAIT && !div_busy)
        begin
            nw_reg <= (total_reg == '0) ? '0 : div_quot;
        end
        if (state_reg == qsp_pkg::ST_MUL)
        begin
            prod_reg  <= prod_next;
            coeff_reg <= coeff_next;
        end
        if (state_reg == qsp_pkg::ST_EMIT)
        begin
            acc_reg       <= row_lend_reg ? '0 : acc_sum;
            dir_out_reg   <= qsp_pkg::IDX_W'(i_reg);
            nw_out_reg    <= nw_reg;
            coeff_out_reg <= coeff_reg;
            pm_out_reg    <= pm_reg;
            px_out_reg    <= px_reg;
            pb_out_reg    <= pb_reg;
            ovf_out_reg   <= ovf_reg;
            last_out_reg  <= is_last;
        end
    end

    assign result_valid = res_valid_reg;
    assign direction    = dir_out_reg;
    assign norm_weight  = nw_out_reg;
    assign diff_coeff   = coeff_out_reg;
    assign mu_partner   = pm_out_reg;
    assign xi_partner   = px_out_reg;
    assign both_partner = pb_out_reg;
    assign overflowed   = ovf_out_reg;
    assign last         = last_out_reg;

    // A result strobe only ever follows the emit step.
    a_strobe_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == qsp_pkg::ST_EMIT))
        else $error("result strobe without emit step");

    // The final result leaves the set empty.
    a_last_clears_set: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> (count_reg == '0 && !ovf_reg) || $past(accept))
        else $error("set not cleared after final result");

    // The normalised weight is never taken before the divider has finished.
    a_div_done_at_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qsp_pkg::ST_MUL || state_reg == qsp_pkg::ST_EMIT) |-> !div_busy)
        else $error("divider still running at emit");

    // Loading never runs past the memory capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_DIRECTIONS))
        else $error("direction count beyond capacity");

endmodule

`default_nettype wire

### rtl/core/qsp_ram.sv
`default_nettype none

module qsp_ram #(
    parameter int WIDTH = qsp_pkg::RAM_W,
    parameter int DEPTH = qsp_pkg::MAX_DIRECTIONS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/core/qsp_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in the quotient width, so the upper dividend half starts
// below the divisor.
module qsp_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [qsp_pkg::DVD_W-1:0]     dividend,
    input  wire logic [qsp_pkg::TOTAL_W-1:0]   divisor,
    output      logic                          busy,
    output      logic [qsp_pkg::WGT_W-1:0]     quotient
);

    logic [qsp_pkg::TOTAL_W-1:0]   rem_reg, rem_next;
    logic [qsp_pkg::WGT_W-1:0]     quo_reg, quo_next;
    logic [qsp_pkg::TOTAL_W-1:0]   dsr_reg;
    logic [qsp_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [qsp_pkg::TOTAL_W:0]     trial;

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;
    assign trial    = {rem_reg, quo_reg[qsp_pkg::WGT_W-1]};

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = qsp_pkg::TOTAL_W'(dividend[qsp_pkg::DVD_W-1:qsp_pkg::WGT_W]);
            quo_next = dividend[qsp_pkg::WGT_W-1:0];
            cnt_next = qsp_pkg::DIV_CNT_W'(qsp_pkg::DIV_STEPS);
        end
        else if (busy)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = qsp_pkg::TOTAL_W'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[qsp_pkg::WGT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[qsp_pkg::TOTAL_W-1:0];
                quo_next = {quo_reg[qsp_pkg::WGT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

endmodule

`default_nettype wire

### tb/quadrature_set_postprocess_tb.sv
module quadrature_set_postprocess_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int CAPACITY      = qsp_pkg::MAX_DIRECTIONS_DEF;
    // Idle cycles allowed after the last result before the tolerance is touched.
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 200;
    // Set far above the length of the slowest correct run.
    localparam int CYCLE_LIMIT   = 500000;

    // What the driver does with the entry at the head of its queue.
    typedef enum logic [1:0] {
        KIND_DIRECTION,   // one load request
        KIND_TOLERANCE,   // one write of the tolerance register
        KIND_DRAIN        // hold off until every expected result has come
    } pending_kind_t;

    typedef struct {
        pending_kind_t                    kind;
        logic signed [qsp_pkg::COS_W-1:0] mu;
        logic signed [qsp_pkg::COS_W-1:0] xi;
        logic [qsp_pkg::WGT_W-1:0]        weight;
        logic                             lend;
        logic                             send;
        logic [qsp_pkg::TOL_W-1:0]        tol;
        int unsigned                      idle_pct;
    } pending_t;

    typedef struct {
        logic [qsp_pkg::IDX_W-1:0]         index;
        logic [qsp_pkg::WGT_W-1:0]         weight;
        logic signed [qsp_pkg::COEF_W-1:0] coeff;
        logic [qsp_pkg::IDX_W-1:0]         mu_mate;
        logic [qsp_pkg::IDX_W-1:0]         xi_mate;
        logic [qsp_pkg::IDX_W-1:0]         both_mate;
        logic                              overflow;
        logic                              is_last;
    } dir_result_t;

    // Clock, reset and every input of the block start at a known value.
    logic                              clk        = 1'b0;
    logic                              rst_n      = 1'b0;
    logic                              cfg_we     = 1'b0;
    logic [qsp_pkg::TOL_W-1:0]         cfg_wdata  = '0;
    logic                              start      = 1'b0;
    logic signed [qsp_pkg::COS_W-1:0]  dir_mu     = '0;
    logic signed [qsp_pkg::COS_W-1:0]  dir_xi     = '0;
    logic [qsp_pkg::WGT_W-1:0]         raw_weight = '0;
    logic                              level_end  = 1'b0;
    logic                              set_end    = 1'b0;

    logic                              busy;
    logic                              result_valid;
    logic [qsp_pkg::IDX_W-1:0]         direction;
    logic [qsp_pkg::WGT_W-1:0]         norm_weight;
    logic signed [qsp_pkg::COEF_W-1:0] diff_coeff;
    logic [qsp_pkg::IDX_W-1:0]         mu_partner;
    logic [qsp_pkg::IDX_W-1:0]         xi_partner;
    logic [qsp_pkg::IDX_W-1:0]         both_partner;
    logic                              overflowed;
    logic                              last;

    // Stimulus waiting to be driven, and results predicted but not yet seen.
    pending_t    pending[$];
    dir_result_t expected_results[$];

    // Our own copy of the direction memory, the set bookkeeping and the register.
    logic signed [qsp_pkg::COS_W-1:0] mu_mem[CAPACITY];
    logic signed [qsp_pkg::COS_W-1:0] xi_mem[CAPACITY];
    logic [qsp_pkg::WGT_W-1:0]        weight_mem[CAPACITY];
    logic                             lend_mem[CAPACITY];
    int                               stored_count = 0;
    logic [qsp_pkg::TOTAL_W-1:0]      weight_sum   = '0;
    logic                             dropped_any  = 1'b0;
    logic [qsp_pkg::TOL_W-1:0]        tolerance    = qsp_pkg::TOL_RESET;

    logic                     req_taken       = 1'b0;
    int                       settle_left     = 0;
    int unsigned              sender_idle_pct = 0;
    int                       mismatch_count  = 0;
    int                       cycle_count     = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    quadrature_set_postprocess #(
        .MAX_DIRECTIONS (CAPACITY)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .start        (start),
        .busy         (busy),
        .dir_mu       (dir_mu),
        .dir_xi       (dir_xi),
        .raw_weight   (raw_weight),
        .level_end    (level_end),
        .set_end      (set_end),
        .result_valid (result_valid),
        .direction    (direction),
        .norm_weight  (norm_weight),
        .diff_coeff   (diff_coeff),
        .mu_partner   (mu_partner),
        .xi_partner   (xi_partner),
        .both_partner (both_partner),
        .overflowed   (overflowed),
        .last         (last)
    );

    // Two cosines count as equal in the mirror search when they differ by no
    // more than the current tolerance.
    function automatic bit near(input longint a, input longint b);
        longint gap;
        gap = a - b;
        if (gap < 0)
            gap = -gap;
        return gap <= longint'(tolerance);
    endfunction

    // Stores one accepted direction. On the request that closes the set, works
    // out one result per stored direction and then clears the set.
    task automatic predict_direction(input logic signed [qsp_pkg::COS_W-1:0] mu,
                                     input logic signed [qsp_pkg::COS_W-1:0] xi,
                                     input logic [qsp_pkg::WGT_W-1:0] weight,
                                     input logic lend, input logic send);
        longint          level_sum;
        longint          coeff;
        longint unsigned share;
        longint          mu_i;
        longint          xi_i;
        longint          mu_j;
        longint          xi_j;
        dir_result_t     r;
        if (stored_count < CAPACITY)
        begin
            mu_mem[stored_count]     = mu;
            xi_mem[stored_count]     = xi;
            weight_mem[stored_count] = weight;
            lend_mem[stored_count]   = lend;
            weight_sum               = weight_sum + weight;
            stored_count++;
        end
        else
        begin
            // A full memory drops the direction, but a set end still counts.
            dropped_any = 1'b1;
        end
        if (!send)
            return;
        level_sum = 0;
        for (int i = 0; i < stored_count; i++)
        begin
            mu_i  = mu_mem[i];
            xi_i  = xi_mem[i];
            share = 0;
            if (weight_sum != 0)
                share = (longint'(weight_mem[i]) * 32768 + weight_sum / 2) / weight_sum;
            // The coefficient covers the earlier directions of the level only,
            // rounded to the nearest step with halves going up, then clamped.
            coeff = (8192 - level_sum) >>> 14;
            if (coeff > 32768)
                coeff = 32768;
            if (coeff < -32768)
                coeff = -32768;
            level_sum += longint'(share) * mu_i;
            if (lend_mem[i])
                level_sum = 0;
            r.mu_mate   = '0;
            r.xi_mate   = '0;
            r.both_mate = '0;
            // Later matches overwrite earlier ones, so the last match wins.
            for (int j = 0; j < stored_count; j++)
            begin
                mu_j = mu_mem[j];
                xi_j = xi_mem[j];
                if (near(mu_i, -mu_j) && near(xi_i, xi_j))
                    r.mu_mate = qsp_pkg::IDX_W'(j);
                if (near(mu_i, mu_j) && near(xi_i, -xi_j))
                    r.xi_mate = qsp_pkg::IDX_W'(j);
                if (near(mu_i, -mu_j) && near(xi_i, -xi_j))
                    r.both_mate = qsp_pkg::IDX_W'(j);
            end
            r.index    = qsp_pkg::IDX_W'(i);
            r.weight   = qsp_pkg::WGT_W'(share);
            r.coeff    = qsp_pkg::COEF_W'(coeff);
            r.overflow = dropped_any;
            r.is_last  = (i == stored_count - 1);
            expected_results.push_back(r);
        end
        stored_count = 0;
        weight_sum   = '0;
        dropped_any  = 1'b0;
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want,
                               input int unsigned idx);
        if (got != want)
            report_mismatch($sformatf("direction %0d %s: got %0d, expected %0d",
                                      idx, name, got, want));
    endtask

    // Compares the result on the ports with the oldest expectation.
    task automatic check_result();
        dir_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("result for direction %0d with nothing expected",
                                      direction));
            return;
        end
        want = expected_results.pop_front();
        check_field("direction", direction, want.index, want.index);
        check_field("norm_weight", norm_weight, want.weight, want.index);
        check_field("diff_coeff", diff_coeff, want.coeff, want.index);
        check_field("mu_partner", mu_partner, want.mu_mate, want.index);
        check_field("xi_partner", xi_partner, want.xi_mate, want.index);
        check_field("both_partner", both_partner, want.both_mate, want.index);
        check_field("overflowed", overflowed, want.overflow, want.index);
        check_field("last", last, want.is_last, want.index);
    endtask

    // Helpers that fill the driver's queue. Each request carries the idle rate
    // of the phase it belongs to.
    task automatic push_direction(input logic signed [qsp_pkg::COS_W-1:0] mu,
                                  input logic signed [qsp_pkg::COS_W-1:0] xi,
                                  input logic [qsp_pkg::WGT_W-1:0] weight,
                                  input logic lend, input logic send);
        pending_t e;
        e.kind     = KIND_DIRECTION;
        e.mu       = mu;
        e.xi       = xi;
        e.weight   = weight;
        e.lend     = lend;
        e.send     = send;
        e.tol      = '0;
        e.idle_pct = sender_idle_pct;
        pending.push_back(e);
    endtask

    task automatic push_drain();
        pending_t e;
        e = '{kind: KIND_DRAIN, default: '0};
        pending.push_back(e);
    endtask

    // The tolerance is only ever written once the block has gone quiet.
    task automatic push_tolerance(input logic [qsp_pkg::TOL_W-1:0] tol);
        pending_t e;
        push_drain();
        e     = '{kind: KIND_TOLERANCE, default: '0};
        e.tol = tol;
        pending.push_back(e);
    endtask

    // One set of n directions. Most sets draw their cosines from a small
    // palette with a sign flip and a one-step jitter, so that mirror partners
    // sit right at the edge of the tolerance; one set in ten is pure noise.
    task automatic queue_random_set(input int unsigned n);
        logic signed [qsp_pkg::COS_W-1:0] mu_pal[3];
        logic signed [qsp_pkg::COS_W-1:0] xi_pal[3];
        logic signed [qsp_pkg::COS_W-1:0] mu;
        logic signed [qsp_pkg::COS_W-1:0] xi;
        logic [qsp_pkg::WGT_W-1:0]        weight;
        bit                               noisy;
        noisy = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < 3; k++)
        begin
            mu_pal[k] = qsp_pkg::COS_W'($urandom_range(0, 16384));
            xi_pal[k] = qsp_pkg::COS_W'($urandom_range(0, 16384));
        end
        for (int unsigned k = 0; k < n; k++)
        begin
            if (noisy)
            begin
                mu = qsp_pkg::COS_W'($urandom);
                xi = qsp_pkg::COS_W'($urandom);
            end
            else if ($urandom_range(0, 9) < 8)
            begin
                mu = qsp_pkg::COS_W'(int'(mu_pal[$urandom_range(0, 2)])
                                     + int'($urandom_range(0, 2)) - 1);
                xi = qsp_pkg::COS_W'(int'(xi_pal[$urandom_range(0, 2)])
                                     + int'($urandom_range(0, 2)) - 1);
                if ($urandom_range(0, 1) != 0)
                    mu = -mu;
                if ($urandom_range(0, 1) != 0)
                    xi = -xi;
            end
            else
            begin
                mu = qsp_pkg::COS_W'(int'($urandom_range(0, 32768)) - 16384);
                xi = qsp_pkg::COS_W'(int'($urandom_range(0, 32768)) - 16384);
            end
            case ($urandom_range(0, 9))
                0:       weight = '0;
                1:       weight = '1;
                default: weight = qsp_pkg::WGT_W'($urandom);
            endcase
            push_direction(mu, xi, weight, $urandom_range(0, 3) == 0, k == n - 1);
        end
    endtask

    // A phase opens with one large set, then mostly small ones, with the odd
    // pause for every result to drain out.
    task automatic queue_phase(input int unsigned budget, input int unsigned opening);
        int unsigned queued;
        int unsigned n;
        queue_random_set(opening);
        queued = opening;
        while (queued < budget)
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 32) : $urandom_range(1, 10);
            queue_random_set(n);
            queued += n;
            if ($urandom_range(0, 7) == 0)
                push_drain();
        end
    endtask

    // Driver. Inputs change on the falling edge. A request stays on the ports
    // until the monitor has seen it taken; the next entry is only looked at
    // after that, so start never drops between back-to-back requests.
    always @(negedge clk)
    begin : drive_requests
        pending_t head;
        logic     want_req;
        logic     want_cfg;
        if (rst_n && !(start && !req_taken))
        begin
            want_req = 1'b0;
            want_cfg = 1'b0;
            if (settle_left != 0)
            begin
                settle_left = settle_left - 1;
            end
            else if (pending.size() != 0)
            begin
                head = pending[0];
                case (head.kind)
                    KIND_DIRECTION:
                    begin
                        if ($urandom_range(0, 99) >= head.idle_pct)
                        begin
                            want_req = 1'b1;
                            dir_mu     <= head.mu;
                            dir_xi     <= head.xi;
                            raw_weight <= head.weight;
                            level_end  <= head.lend;
                            set_end    <= head.send;
                            void'(pending.pop_front());
                        end
                    end
                    KIND_TOLERANCE:
                    begin
                        want_cfg = 1'b1;
                        cfg_wdata <= head.tol;
                        void'(pending.pop_front());
                    end
                    KIND_DRAIN:
                    begin
                        // Wait for the last result and for busy to fall, then
                        // give the block a little longer before moving on.
                        if (expected_results.size() == 0 && !busy)
                        begin
                            settle_left = SETTLE_CYCLES;
                            void'(pending.pop_front());
                        end
                    end
                    default: void'(pending.pop_front());
                endcase
            end
            start  <= want_req;
            cfg_we <= want_cfg;
        end
    end

    // Monitor. Everything is sampled on the rising edge: register writes and
    // accepted requests update the prediction, and each result strobe is
    // checked at once since the block cannot be held off.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_taken <= start && !busy;
            if (cfg_we)
                tolerance = cfg_wdata;
            if (start && !busy)
                predict_direction(dir_mu, dir_xi, raw_weight, level_end, set_end);
            if (result_valid)
                check_result();
        end
    end

    // Watchdog: a hung block or a lost result ends the run here.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        // Directed sets, under the reset tolerance first.
        sender_idle_pct = 9;
        // A single direction at the extremes of the range, taking all the weight.
        push_direction(16384, -16384, 16'hFFFF, 1'b0, 1'b1);
        // All the weight on mu = -1 scaled twice over: the coefficient clamps high.
        push_direction(-32768, 32767, 16'd1, 1'b0, 1'b0);
        push_direction(0, 0, 16'd0, 1'b1, 1'b1);
        // The same on the largest positive pattern: it clamps low.
        push_direction(32767, -32768, 16'd40000, 1'b0, 1'b0);
        push_direction(100, 0, 16'd0, 1'b0, 1'b1);
        // Zero weight total, a level boundary, and two candidates for one mirror
        // so that the later one has to win.
        push_direction(8000, 4000, 16'd0, 1'b0, 1'b0);
        push_direction(-8000, 4000, 16'd0, 1'b1, 1'b0);
        push_direction(8000, -4000, 16'd0, 1'b0, 1'b0);
        push_direction(-8002, 4001, 16'd0, 1'b0, 1'b0);
        push_direction(-8000, -3999, 16'd0, 1'b0, 1'b1);
        // Exact matching only.
        push_tolerance('0);
        push_direction(5000, 3000, 16'd300, 1'b0, 1'b0);
        push_direction(-5000, 3000, 16'd200, 1'b1, 1'b0);
        push_direction(5000, -3000, 16'd100, 1'b0, 1'b0);
        push_direction(-5000, -3001, 16'hFFFF, 1'b0, 1'b1);
        // The widest register value: every pair matches, so the partner is
        // always the final direction.
        push_tolerance('1);
        push_direction(1000, 500, 16'd7, 1'b0, 1'b0);
        push_direction(-1000, -500, 16'd9, 1'b1, 1'b0);
        push_direction(700, -200, 16'd11, 1'b0, 1'b0);
        push_direction(0, 0, 16'd13, 1'b0, 1'b1);
        // A tolerance of 1024, with a match exactly at the limit.
        push_tolerance(11'd1024);
        push_direction(16384, 16384, 16'hFFFF, 1'b0, 1'b0);
        push_direction(-16384, -16384, 16'hFFFF, 1'b1, 1'b0);
        push_direction(15360, -15360, 16'd1, 1'b0, 1'b1);

        // Random phases: a full set, an overfull set and a large partial set
        // open them in turn, and the sender's idle rate changes between them.
        push_tolerance(qsp_pkg::TOL_W'($urandom_range(0, 4)));
        queue_phase(115, CAPACITY);
        sender_idle_pct = 45;
        push_tolerance(qsp_pkg::TOL_W'($urandom_range(0, 4)));
        queue_phase(115, CAPACITY + $urandom_range(1, 3));
        sender_idle_pct = 0;
        push_tolerance(qsp_pkg::TOL_W'($urandom_range(0, 4)));
        queue_phase(120, $urandom_range(33, 48));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Run until every request has been taken and every result has come.
        do
            @(posedge clk);
        while (pending.size() != 0 || start || expected_results.size() != 0 || busy);
        // Any stray result after this point is still caught by the monitor.
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### filelist.f
rtl/core/qsp_pkg.sv
rtl/core/qsp_ram.sv
rtl/core/qsp_div.sv
rtl/core/quadrature_set_postprocess.sv
tb/quadrature_set_postprocess_tb.sv
